[rtl/modbus_read_response_checker_unit_assert.svh]
// ----------------------------------------------------------------------------
// modbus read response checker assertion macros
// short forms for clocked implication properties used by the checker
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_READ_RESPONSE_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define MRRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrrc assertion failed");

// next-cycle implication
`define MRRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrrc assertion failed");

`endif

[rtl/mrrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrrc_pkg
// shared widths, codes and the crc-16/modbus byte update
// ----------------------------------------------------------------------------
package mrrc_pkg;

  localparam int ACTION_W    = 2;
  localparam int BYTE_W      = 8;
  localparam int TICK_W      = 24;
  localparam int STATUS_W    = 3;
  localparam int VALUE_W     = 16;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CRC_W       = 16;
  localparam int HDR_BYTES   = 5;
  localparam int MIN_FRAME   = 5;
  localparam int LEN_MAX     = 63;

  localparam int MAX_FRAME_BYTES_DEF = 32;

  localparam logic [TICK_W-1:0] TICK_MAX          = '1;
  localparam logic [TICK_W-1:0] RESP_TIMEOUT_RST  = 24'd100000;
  localparam logic [TICK_W-1:0] INTERCHAR_RST     = 24'd1000;
  localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [BYTE_W-1:0] DATA_BYTES        = 8'h02;
  localparam logic [CRC_W-1:0]  CRC_INIT          = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY          = 16'hA001;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESP_TIMEOUT = 2'd0,
    CFG_INTERCHAR    = 2'd1
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_HEADER = 3'd2,
    ST_COUNT  = 3'd3,
    ST_CRC    = 3'd4
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic [LEN_W-1:0]     length;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/modbus_read_response_checker_unit.sv]
// ----------------------------------------------------------------------------
// modbus_read_response_checker_unit
// collects a modbus rtu reply to a single-register read and checks it
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, action, rx_byte,       | in beat
//          | slave_address                              |
//  out     | out_valid, out_stall, status,              | out beat
//          | register_value, frame_length               |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | write beat
//
//  one in beat per cycle; a result appears in out registers the cycle after
//  the closing beat, or in the skid entry if out is stalled. the two-entry
//  output (register plus skid) holds results while out stalls; in stalls
//  only once the skid is full. crc update is one byte per beat, combinational.
//  rst is synchronous and restores the idle state and reset config values.
// ----------------------------------------------------------------------------
module modbus_read_response_checker_unit #(
  parameter int MAX_FRAME_BYTES = mrrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mrrc_pkg::ACTION_W-1:0]  action,
  input  logic [mrrc_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [mrrc_pkg::BYTE_W-1:0]    slave_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mrrc_pkg::STATUS_W-1:0]  status,
  output logic [mrrc_pkg::VALUE_W-1:0]   register_value,
  output logic [mrrc_pkg::LEN_W-1:0]     frame_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrrc_pkg::TICK_W-1:0]    cfg_data
);
  import mrrc_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EW = (CW > LEN_W) ? CW : LEN_W;

  logic [TICK_W-1:0] resp_timeout;
  logic [TICK_W-1:0] interchar;

  logic              receiving, receiving_next;
  logic [BYTE_W-1:0] expected_address, expected_address_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [TICK_W-1:0] silence_ticks, silence_ticks_next;
  logic [CW-1:0]     bytes_seen, bytes_seen_next;
  logic [CRC_W-1:0]  running_crc, running_crc_next;
  logic [BYTE_W-1:0] delayed0, delayed0_next;
  logic [BYTE_W-1:0] delayed1, delayed1_next;
  logic [BYTE_W-1:0] header_bytes [HDR_BYTES];
  logic [BYTE_W-1:0] header_bytes_next [HDR_BYTES];

  logic              accept;
  logic              close;
  logic              hdr_write;
  result_t           res;
  logic [EW-1:0]     bytes_ext;

  result_t           out_reg;
  result_t           skid;
  logic              skid_valid;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;
  assign hdr_write = accept && receiving && (action_t'(action) == ACT_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_timeout <= RESP_TIMEOUT_RST;
      interchar    <= INTERCHAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RESP_TIMEOUT: resp_timeout <= cfg_data;
        CFG_INTERCHAR:    interchar    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    receiving_next        = receiving;
    expected_address_next = expected_address;
    elapsed_ticks_next    = elapsed_ticks;
    silence_ticks_next    = silence_ticks;
    bytes_seen_next       = bytes_seen;
    running_crc_next      = running_crc;
    delayed0_next         = delayed0;
    delayed1_next         = delayed1;
    close                 = 1'b0;
    if (accept) begin
      unique case (action_t'(action))
        ACT_START: begin
          receiving_next        = 1'b1;
          expected_address_next = slave_address;
          elapsed_ticks_next    = '0;
          silence_ticks_next    = '0;
          bytes_seen_next       = '0;
          running_crc_next      = CRC_INIT;
          delayed0_next         = '0;
          delayed1_next         = '0;
        end
        ACT_BYTE: begin
          if (receiving) begin
            if (bytes_seen >= CW'(2)) begin
              running_crc_next = crc_feed(running_crc, delayed0);
            end
            delayed0_next      = delayed1;
            delayed1_next      = rx_byte;
            bytes_seen_next    = bytes_seen + CW'(1);
            silence_ticks_next = '0;
            close = (bytes_seen_next >= CW'(MAX_FRAME_BYTES)) ||
                    (elapsed_ticks > resp_timeout);
          end
        end
        ACT_TICK: begin
          if (receiving) begin
            if (elapsed_ticks != TICK_MAX) begin
              elapsed_ticks_next = elapsed_ticks + TICK_W'(1);
            end
            if (silence_ticks != TICK_MAX) begin
              silence_ticks_next = silence_ticks + TICK_W'(1);
            end
            close = silence_ticks_next > interchar;
          end
        end
        default: ;
      endcase
    end
    if (close) begin
      receiving_next = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      header_bytes_next[i] = (hdr_write && bytes_seen == CW'(i)) ? rx_byte : header_bytes[i];
    end
  end

  // result from the post-update frame state
  always_comb begin
    bytes_ext = EW'(bytes_seen_next);
    res.value = '0;
    if (bytes_seen_next < CW'(MIN_FRAME)) begin
      res.status = ST_SHORT;
    end else if (header_bytes_next[0] != expected_address_next ||
                 header_bytes_next[1] != FUNC_READ_HOLDING) begin
      res.status = ST_HEADER;
    end else if (header_bytes_next[2] != DATA_BYTES) begin
      res.status = ST_COUNT;
    end else if ({delayed1_next, delayed0_next} != running_crc_next) begin
      res.status = ST_CRC;
    end else begin
      res.status = ST_OK;
      res.value  = {header_bytes_next[3], header_bytes_next[4]};
    end
    res.length = (bytes_ext > EW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(bytes_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving        <= 1'b0;
      expected_address <= '0;
      elapsed_ticks    <= '0;
      silence_ticks    <= '0;
      bytes_seen       <= '0;
      running_crc      <= CRC_INIT;
      delayed0         <= '0;
      delayed1         <= '0;
    end else begin
      receiving        <= receiving_next;
      expected_address <= expected_address_next;
      elapsed_ticks    <= elapsed_ticks_next;
      silence_ticks    <= silence_ticks_next;
      bytes_seen       <= bytes_seen_next;
      running_crc      <= running_crc_next;
      delayed0         <= delayed0_next;
      delayed1         <= delayed1_next;
    end
  end

  always_ff @(posedge clk) begin
    header_bytes <= header_bytes_next;
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (close) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= close;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (close) begin
        skid <= res;
      end
    end else if (skid_valid) begin
      out_reg <= skid;
    end else begin
      out_reg <= res;
    end
  end

  assign status         = out_reg.status;
  assign register_value = out_reg.value;
  assign frame_length   = out_reg.length;

endmodule

[rtl/mrrc_checker.sv]
// ----------------------------------------------------------------------------
// mrrc_checker
// port-level checks on the read response checker, bound to the checker unit
// ----------------------------------------------------------------------------
`include "modbus_read_response_checker_unit_assert.svh"

module mrrc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mrrc_pkg::STATUS_W-1:0]  status,
  input logic [mrrc_pkg::VALUE_W-1:0]   register_value,
  input logic [mrrc_pkg::LEN_W-1:0]     frame_length
);
  import mrrc_pkg::*;

  `MRRC_ASSERT_SAME(a_status_code, out_valid, status <= ST_CRC)
  `MRRC_ASSERT_SAME(a_value_zero_on_error, out_valid && status != ST_OK, register_value == '0)
  `MRRC_ASSERT_SAME(a_short_matches_length, out_valid,
                    (status == ST_SHORT) == (frame_length < LEN_W'(MIN_FRAME)))
  `MRRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(status) && $stable(register_value) &&
                    $stable(frame_length))

endmodule

bind modbus_read_response_checker_unit mrrc_checker u_mrrc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .register_value (register_value),
  .frame_length   (frame_length)
);
